// File: rtl/rppr_pkg.sv
// Package for the radio packet page reassembler.
// Holds the sizes, the command and verdict codes and the structs passed between modules.
// No dependencies.
package rppr_pkg;

    localparam int PAGE_BYTES   = 512;
    localparam int PACKET_BYTES = 32;

    // Page store address, committed length and packet byte position widths
    localparam int ADDR_W = $clog2(PAGE_BYTES);
    localparam int FILL_W = $clog2(PAGE_BYTES + 1);
    localparam int POS_W  = $clog2(PACKET_BYTES + 2);

    typedef enum logic [1:0] {
        CMD_PACKET = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        V_ACCEPTED = 3'd0,
        V_BAD_CHECK = 3'd1,
        V_MISSED   = 3'd2,
        V_CONTROL  = 3'd3,
        V_OVERSIZE = 3'd4
    } verdict_t;

    // Store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    // Result of one request, as known at acceptance
    typedef struct packed {
        logic              emit;
        verdict_t          verdict;
        logic [3:0]        pn;
        logic              stream;
        logic              complete;
        logic [FILL_W-1:0] length;
        logic              rd_sel;
    } res_t;

endpackage

// File: rtl/rppr_page_ram.sv
// Generic single write, single read port synchronous RAM, registered read data.
// Used as the page store. No dependencies.
module rppr_page_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rppr_track.sv
// Packet tracking for the page reassembler: header, check sum, sequence and fill state.
// Produces the store write and the result of each accepted request. Depends on rppr_pkg.
module rppr_track (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           acc,
    input  rppr_pkg::cmd_t                 cmd,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [rppr_pkg::ADDR_W-1:0]    read_index,
    output rppr_pkg::wr_t                  wr,
    output rppr_pkg::res_t                 res
);

    localparam int FW = rppr_pkg::FILL_W;
    localparam int PW = rppr_pkg::POS_W;

    logic [FW-1:0] fill_reg, fill_next;
    logic [3:0]    prev_reg, prev_next;
    logic [PW-1:0] pos_reg,  pos_next;
    logic [7:0]    hdr_reg,  hdr_next;
    logic [2:0]    sum_reg,  sum_next;
    logic          done_reg, done_next;

    logic          pos_is_hdr;
    logic          staged;
    logic [7:0]    hdr_eff;
    logic [2:0]    sum_eff;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] payload;
    logic [FW:0]   wr_addr_full;
    logic [FW:0]   fill_sum;
    logic [FW-1:0] fill_cap;
    logic [3:0]    pn;
    logic          chk_ok;
    logic          seq_done;
    logic          seq_good;
    logic [3:0]    seq_prev;

    // Current byte as seen against the packet in progress
    always_comb
    begin
        pos_is_hdr   = (pos_reg == '0);
        staged       = !pos_is_hdr && (pos_reg < PW'(rppr_pkg::PACKET_BYTES));
        hdr_eff      = pos_is_hdr ? data_byte : hdr_reg;
        sum_eff      = pos_is_hdr ? 3'd0 : (staged ? sum_reg + data_byte[2:0] : sum_reg);
        pos_inc      = (pos_reg <= PW'(rppr_pkg::PACKET_BYTES)) ? pos_reg + 1'b1 : pos_reg;
        payload      = pos_inc - 1'b1;
        wr_addr_full = {1'b0, fill_reg} + (FW+1)'(pos_reg) - 1'b1;
        fill_sum     = {1'b0, fill_reg} + (FW+1)'(payload);
        fill_cap     = (fill_sum > (FW+1)'(rppr_pkg::PAGE_BYTES)) ?
                       FW'(rppr_pkg::PAGE_BYTES) : fill_sum[FW-1:0];
        pn           = hdr_eff[6:3];
        chk_ok       = (hdr_eff[2:0] == 3'(3'd0 - sum_eff));
    end

    // Sequence check against the previous packet number
    always_comb
    begin
        seq_done = 1'b0;
        seq_good = 1'b1;
        seq_prev = prev_reg;
        if (pn == 4'd0 && prev_reg == 4'd0)
        begin
            seq_done = 1'b1;
        end
        else if (prev_reg == 4'd0)
        begin
            seq_prev = pn;
        end
        else if ({1'b0, prev_reg} == {1'b0, pn} + 5'd1)
        begin
            seq_prev = pn;
            seq_done = (pn == 4'd0);
        end
        else
        begin
            seq_good = 1'b0;
            seq_prev = 4'd0;
        end
    end

    // Staging write into the store just past the committed length
    always_comb
    begin
        wr.en   = acc && (cmd == rppr_pkg::CMD_PACKET) && staged &&
                  (wr_addr_full < (FW+1)'(rppr_pkg::PAGE_BYTES));
        wr.addr = wr_addr_full[rppr_pkg::ADDR_W-1:0];
        wr.data = data_byte;
    end

    // Next state and result
    always_comb
    begin
        fill_next    = fill_reg;
        prev_next    = prev_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        sum_next     = sum_reg;
        done_next    = done_reg;
        res.emit     = 1'b0;
        res.verdict  = rppr_pkg::V_ACCEPTED;
        res.pn       = 4'd0;
        res.stream   = 1'b0;
        res.complete = done_reg;
        res.length   = fill_reg;
        res.rd_sel   = 1'b0;
        if (acc)
        begin
            case (cmd)
                rppr_pkg::CMD_READ:
                begin
                    res.emit   = 1'b1;
                    res.rd_sel = ({1'b0, read_index} < fill_reg);
                end
                rppr_pkg::CMD_CLEAR:
                begin
                    fill_next    = '0;
                    done_next    = 1'b0;
                    pos_next     = '0;
                    sum_next     = 3'd0;
                    res.emit     = 1'b1;
                    res.complete = 1'b0;
                    res.length   = '0;
                end
                rppr_pkg::CMD_PACKET:
                begin
                    hdr_next = hdr_eff;
                    sum_next = sum_eff;
                    pos_next = pos_inc;
                    if (last_byte)
                    begin
                        pos_next   = '0;
                        sum_next   = 3'd0;
                        res.emit   = 1'b1;
                        res.pn     = pn;
                        res.stream = hdr_eff[7];
                        if (pos_inc > PW'(rppr_pkg::PACKET_BYTES))
                        begin
                            res.verdict = rppr_pkg::V_OVERSIZE;
                        end
                        else if (pos_inc < PW'(2))
                        begin
                            res.verdict = rppr_pkg::V_CONTROL;
                        end
                        else if (!chk_ok)
                        begin
                            res.verdict = rppr_pkg::V_BAD_CHECK;
                        end
                        else if (!seq_good)
                        begin
                            res.verdict = rppr_pkg::V_MISSED;
                            fill_next   = '0;
                            prev_next   = 4'd0;
                        end
                        else
                        begin
                            prev_next = seq_prev;
                            if (!hdr_eff[7])
                            begin
                                fill_next = fill_cap;
                                if (seq_done)
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        res.complete = done_next;
                        res.length   = fill_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            prev_reg <= 4'd0;
            pos_reg  <= '0;
            hdr_reg  <= 8'd0;
            sum_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            prev_reg <= prev_next;
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            sum_reg  <= sum_next;
            done_reg <= done_next;
        end
    end

endmodule

// File: rtl/radio_packet_page_reassembler.sv
// Radio packet page reassembler, top level.
// Channels: one request channel (cmd, data_byte, last_byte, read_index) and one result
// channel (verdict, packet_number, is_stream, page_complete, page_length, read_data),
// each with valid and ready; a request moves when valid and ready are both high.
// Packet bytes come in with cmd 0, header byte first, last_byte on the final one;
// the final byte yields one result with the packet verdict. cmd 1 reads one page byte,
// cmd 2 clears the page, each yielding one result; cmd 3 and inner bytes yield none.
// Throughput: one request per cycle while in_ready is high. Packet and clear requests
// update the tracking state; every request does at most one store write or one store
// read in its accept cycle. The result stage and the page store's registered read are
// loaded at the accepting edge, and the output register from them when the result
// stage advances.
// The result channel holds its item while out_ready is low; the stage in front keeps
// one more item, so in_ready drops only when both are full.
// Reset clears the fill count, sequence and packet state and empties both stages at
// once; the page store is not cleared, as only committed bytes are ever read.
// Depends on rppr_pkg, rppr_track and rppr_page_ram.
module radio_packet_page_reassembler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [rppr_pkg::ADDR_W-1:0]   read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    verdict,
    output logic [3:0]                    packet_number,
    output logic                          is_stream,
    output logic                          page_complete,
    output logic [rppr_pkg::FILL_W-1:0]   page_length,
    output logic [7:0]                    read_data
);

    logic           in_acc;
    logic           s1_adv;
    rppr_pkg::wr_t  trk_wr;
    rppr_pkg::res_t trk_res;
    logic [7:0]     ram_rdata;

    logic           s1_valid_reg, s1_valid_next;
    rppr_pkg::res_t s1_res_reg;
    logic           out_valid_reg, out_valid_next;
    rppr_pkg::res_t out_res_reg;
    logic [7:0]     out_data_reg;

    // Handshake: the result stage moves forward when the output is empty or taken
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    rppr_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (in_acc),
        .cmd        (rppr_pkg::cmd_t'(cmd)),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .read_index (read_index),
        .wr         (trk_wr),
        .res        (trk_res)
    );

    rppr_page_ram #(
        .DEPTH (rppr_pkg::PAGE_BYTES),
        .WIDTH (8)
    ) u_page_ram (
        .clk   (clk),
        .we    (trk_wr.en),
        .waddr (trk_wr.addr),
        .wdata (trk_wr.data),
        .re    (trk_res.rd_sel),
        .raddr (read_index),
        .rdata (ram_rdata)
    );

    // Stage valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = trk_res.emit;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_res_reg <= trk_res;
        end
        if (s1_adv)
        begin
            out_res_reg  <= s1_res_reg;
            out_data_reg <= s1_res_reg.rd_sel ? ram_rdata : 8'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = out_res_reg.verdict;
    assign packet_number = out_res_reg.pn;
    assign is_stream     = out_res_reg.stream;
    assign page_complete = out_res_reg.complete;
    assign page_length   = out_res_reg.length;
    assign read_data     = out_data_reg;

    // Committed length never passes the page size
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (page_length <= rppr_pkg::FILL_W'(rppr_pkg::PAGE_BYTES)))
        else $error("page length beyond page size");

    // Only read results carry store data
    a_rd_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict != rppr_pkg::V_ACCEPTED) |-> (read_data == 8'd0))
        else $error("read data on a verdict result");

    // Every read and clear request produces a result in the next stage
    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (cmd == rppr_pkg::CMD_READ || cmd == rppr_pkg::CMD_CLEAR))
        |=> s1_valid_reg)
        else $error("read or clear request lost");

    // A store read only starts when the result stage is free to take it
    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        trk_res.rd_sel |-> (!s1_valid_reg || s1_adv))
        else $error("store read while result stage stalled");

endmodule
